@@ hdl/cas_pkg.sv @@
// Shared types and constants for the cave automaton smoother.
// Used by cas_cfg_regs, cas_cell_rule and the top level; depends on nothing.
`default_nettype none

package cas_pkg;

	localparam int CELLS_W         = 64;
	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int COUNT_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MIN   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] PASS_COUNT_RST  = 4'd10;
	localparam logic [CFG_DATA_W-1:0] SURVIVE_MIN_RST = 4'd3;
	localparam logic [CFG_DATA_W-1:0] BIRTH_MIN_RST   = 4'd6;

	typedef logic [CELLS_W-1:0] cells_t;

	typedef struct packed {
		cells_t row_cells;
		logic   row_last;
	} row_t;

	typedef struct packed {
		cells_t out_cells;
		logic   out_last;
	} res_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pass_count;
		logic [CFG_DATA_W-1:0] survive_min;
		logic [CFG_DATA_W-1:0] birth_min;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/cas_grid_mem.sv @@
// Grid row memory: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module cas_grid_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/cas_cfg_regs.sv @@
// Configuration registers: pass count and the two neighbor thresholds.
// Depends on cas_pkg.
`default_nettype none

module cas_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data,
	output cas_pkg::cfg_t                  cfg
);
	import cas_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pass_count  <= PASS_COUNT_RST;
			cfg_q.survive_min <= SURVIVE_MIN_RST;
			cfg_q.birth_min   <= BIRTH_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PASS_COUNT:  cfg_q.pass_count  <= cfg_data;
				REG_SURVIVE_MIN: cfg_q.survive_min <= cfg_data;
				REG_BIRTH_MIN:   cfg_q.birth_min   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

endmodule

`default_nettype wire

@@ hdl/cas_cell_rule.sv @@
// Neighbor count and survive/birth rule for one cell of the working row.
// Depends on cas_pkg.
`default_nettype none

module cas_cell_rule #(
	parameter int GRID_WIDTH = 64
) (
	input  logic [GRID_WIDTH-1:0]         up,
	input  logic [GRID_WIDTH-1:0]         cur,
	input  logic [GRID_WIDTH-1:0]         down,
	input  logic [$clog2(GRID_WIDTH)-1:0] x,
	input  cas_pkg::cfg_t                 cfg,
	output logic                          wall_next
);
	import cas_pkg::*;

	localparam int XW = $clog2(GRID_WIDTH);

	logic [XW-1:0]      xl;
	logic [XW-1:0]      xr;
	logic [COUNT_W-1:0] count;

	always_comb begin
		xl    = XW'(x - 1'b1);
		xr    = XW'(x + 1'b1);
		count = COUNT_W'(up[xl]) + COUNT_W'(up[x]) + COUNT_W'(up[xr])
		      + COUNT_W'(cur[xl]) + COUNT_W'(cur[xr])
		      + COUNT_W'(down[xl]) + COUNT_W'(down[x]) + COUNT_W'(down[xr]);
		if (count < cfg.survive_min) begin
			wall_next = 1'b0;
		end else if (count >= cfg.birth_min) begin
			wall_next = 1'b1;
		end else begin
			wall_next = cur[x];
		end
	end

endmodule

`default_nettype wire

@@ hdl/cave_automaton_smoother.sv @@
// Cave automaton smoother top level: row loading, smoothing sequencer, row emission.
// Depends on cas_pkg, cas_grid_mem, cas_cfg_regs and cas_cell_rule.
//
// Rows are taken one per cycle into the grid memory until a row marked last (or the
// row at GRID_HEIGHT-1) ends the grid. The block then runs pass_count in-place passes
// (none for a grid of fewer than three rows): for each interior row it reads the row
// above, the row itself and the row below from the single-read-port memory, updates
// one interior cell per cycle, and writes the row back. Rows are then emitted in
// order, each read from memory and then registered to the output; a new row is read
// only when the output register is empty or its row is being taken. No input
// transaction is taken between the last loaded row and the issue of the last emitted
// row.
`default_nettype none

module cave_automaton_smoother #(
	parameter int GRID_WIDTH  = cas_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = cas_pkg::GRID_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           row_valid,
	output logic                           row_stall,
	input  cas_pkg::row_t                  row_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output cas_pkg::res_t                  res_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cas_pkg::*;

	localparam int XW = $clog2(GRID_WIDTH);
	localparam int YW = $clog2(GRID_HEIGHT);
	localparam logic [XW-1:0] X_END    = XW'(GRID_WIDTH - 2);
	localparam logic [YW-1:0] Y_LAST   = YW'(GRID_HEIGHT - 1);
	localparam logic [1:0]    FETCH_END = 2'd3;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_FETCH = 6'b000010,
		S_CELL  = 6'b000100,
		S_WB    = 6'b001000,
		S_ERD   = 6'b010000,
		S_EOUT  = 6'b100000
	} state_t;

	state_t                state_q;
	logic [YW-1:0]         idx_q;
	logic [YW-1:0]         last_q;
	logic [YW-1:0]         y_q;
	logic [YW-1:0]         e_q;
	logic [XW-1:0]         x_q;
	logic [1:0]            f_q;
	logic [CFG_DATA_W-1:0] p_q;
	logic [GRID_WIDTH-1:0] up_q;
	logic [GRID_WIDTH-1:0] cur_q;
	logic [GRID_WIDTH-1:0] down_q;
	logic                  res_valid_q;
	res_t                  res_data_q;

	cfg_t                  cfg;
	logic                  cell_new;
	logic                  row_take;
	logic                  res_take;
	logic                  mem_we;
	logic [YW-1:0]         mem_waddr;
	logic [GRID_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [YW-1:0]         mem_raddr;
	logic [GRID_WIDTH-1:0] mem_rdata;

	cas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cas_grid_mem #(
		.DEPTH (GRID_HEIGHT),
		.WIDTH (GRID_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cas_cell_rule #(
		.GRID_WIDTH (GRID_WIDTH)
	) u_rule (
		.up        (up_q),
		.cur       (cur_q),
		.down      (down_q),
		.x         (x_q),
		.cfg       (cfg),
		.wall_next (cell_new)
	);

	always_comb begin
		row_stall = (state_q != S_LOAD);
		row_take  = row_valid && !row_stall;
		res_take  = res_valid_q && !res_stall;
		mem_we    = 1'b0;
		mem_waddr = y_q;
		mem_wdata = cur_q;
		mem_re    = 1'b0;
		mem_raddr = e_q;
		unique case (state_q)
			S_LOAD: begin
				mem_we    = row_take;
				mem_waddr = idx_q;
				mem_wdata = row_data.row_cells[GRID_WIDTH-1:0];
			end
			S_FETCH: begin
				mem_re    = (f_q != FETCH_END);
				mem_raddr = YW'(y_q + YW'(f_q) - YW'(1));
			end
			S_WB: begin
				mem_we = 1'b1;
			end
			S_ERD: begin
				mem_re = !res_valid_q || res_take;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			idx_q       <= '0;
			last_q      <= '0;
			y_q         <= '0;
			e_q         <= '0;
			x_q         <= '0;
			f_q         <= '0;
			p_q         <= '0;
			up_q        <= '0;
			cur_q       <= '0;
			down_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (row_take) begin
						if (row_data.row_last || idx_q == Y_LAST) begin
							last_q <= idx_q;
							idx_q  <= '0;
							y_q    <= YW'(1);
							f_q    <= '0;
							p_q    <= '0;
							e_q    <= '0;
							if (idx_q < YW'(2) || cfg.pass_count == '0) begin
								state_q <= S_ERD;
							end else begin
								state_q <= S_FETCH;
							end
						end else begin
							idx_q <= YW'(idx_q + 1'b1);
						end
					end
				end
				S_FETCH: begin
					f_q <= f_q + 1'b1;
					case (f_q)
						2'd1: up_q  <= mem_rdata;
						2'd2: cur_q <= mem_rdata;
						2'd3: begin
							down_q  <= mem_rdata;
							x_q     <= XW'(1);
							state_q <= S_CELL;
						end
						default: ;
					endcase
				end
				S_CELL: begin
					cur_q[x_q] <= cell_new;
					if (x_q == X_END) begin
						state_q <= S_WB;
					end else begin
						x_q <= XW'(x_q + 1'b1);
					end
				end
				S_WB: begin
					f_q <= '0;
					if (y_q == YW'(last_q - 1'b1)) begin
						y_q <= YW'(1);
						if (CFG_DATA_W'(p_q + 1'b1) == cfg.pass_count) begin
							state_q <= S_ERD;
						end else begin
							p_q     <= CFG_DATA_W'(p_q + 1'b1);
							state_q <= S_FETCH;
						end
					end else begin
						y_q     <= YW'(y_q + 1'b1);
						state_q <= S_FETCH;
					end
				end
				S_ERD: begin
					if (!res_valid_q || res_take) begin
						state_q <= S_EOUT;
					end
				end
				S_EOUT: begin
					res_valid_q <= 1'b1;
					if (e_q == last_q) begin
						state_q <= S_LOAD;
					end else begin
						e_q     <= YW'(e_q + 1'b1);
						state_q <= S_ERD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EOUT) begin
			res_data_q.out_cells <= cells_t'(mem_rdata);
			res_data_q.out_last  <= (e_q == last_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

`ifndef NO_ASSERTIONS
	a_x_interior: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CELL |-> x_q != '0 && x_q <= X_END)
		else $error("cell column outside interior");

	a_y_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH || state_q == S_CELL || state_q == S_WB)
		|-> y_q != '0 && y_q < last_q)
		else $error("smoothing row outside interior");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EOUT |-> !res_valid_q)
		else $error("output register overwritten while pending");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EOUT && e_q == last_q)
		|=> state_q == S_LOAD && res_valid && res_data.out_last)
		else $error("final row not flagged or loading not resumed");
`endif

endmodule

`default_nettype wire
